// ----- hdl/mnt_pkg.sv -----
package mnt_pkg;

	// Fixed geometry of the table and of the number format.
	localparam int MAX_DIMS    = 4;
	localparam int MAX_CARD    = 16;
	localparam int VALUE_BITS  = 16;
	localparam int ACC_W       = 32;
	localparam int QUEUE_DEPTH = 4;

	// Field widths of the configuration registers and of the results.
	localparam int DIMS_W     = 3;
	localparam int CARD_W     = 5;
	localparam int KEEP_W     = $clog2(MAX_DIMS);
	localparam int BIN_W      = $clog2(MAX_CARD);
	localparam int REG_IDX_W  = 3;
	localparam int REG_DATA_W = 5;

	// Configuration register indexes.
	typedef enum logic [REG_IDX_W-1:0] {
		REG_DIMS  = 3'd0,
		REG_CARD0 = 3'd1,
		REG_CARD1 = 3'd2,
		REG_CARD2 = 3'd3,
		REG_CARD3 = 3'd4,
		REG_KEEP  = 3'd5
	} reg_idx_t;

	// Configuration after clamping to legal ranges.
	typedef struct packed {
		logic [DIMS_W-1:0]                  dims;
		logic [MAX_DIMS-1:0][CARD_W-1:0]    card;
		logic [KEEP_W-1:0]                  keep;
	} eff_cfg_t;

	// One classified entry travelling from the front end to the back end.
	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic [BIN_W-1:0]      bin;
		logic                  last;
	} q_item_t;

	// Back end sequencer states.
	typedef enum logic [1:0] {
		BK_ACC,
		BK_LOAD,
		BK_DIV,
		BK_EMIT
	} back_state_t;

	// A cardinality of zero counts as one; anything above the bin count is capped.
	function automatic logic [CARD_W-1:0] clamp_card(input logic [CARD_W-1:0] c);
		logic [CARD_W-1:0] r;
		r = c;
		if (c == '0) begin
			r = CARD_W'(1);
		end else if (c > CARD_W'(MAX_CARD)) begin
			r = CARD_W'(MAX_CARD);
		end
		return r;
	endfunction

	// Accumulator add that sticks at full scale.
	function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
		input logic [ACC_W-1:0] b);
		logic [ACC_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
	endfunction

endpackage

// ----- hdl/mnt_if.sv -----
// Table entry channel.
interface mnt_entry_if;
	logic                            valid;
	logic                            ready;
	logic [mnt_pkg::VALUE_BITS-1:0]  entry_value;
	logic                            last_entry;

	modport source (output valid, output entry_value, output last_entry, input ready);
	modport sink (input valid, input entry_value, input last_entry, output ready);
endinterface

// Normalized marginal result channel.
interface mnt_result_if;
	logic                            valid;
	logic                            ready;
	logic [mnt_pkg::VALUE_BITS-1:0]  marginal_value;
	logic [mnt_pkg::BIN_W-1:0]       bin_index;
	logic                            last_result;
	logic                            zero_total;

	modport source (output valid, output marginal_value, output bin_index,
		output last_result, output zero_total, input ready);
	modport sink (input valid, input marginal_value, input bin_index,
		input last_result, input zero_total, output ready);
endinterface

// Configuration write channel.
interface mnt_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [mnt_pkg::REG_IDX_W-1:0]   index;
	logic [mnt_pkg::REG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/mnt_front.sv -----
module mnt_front (
	input  logic               clk,
	input  logic               arst_n,
	input  mnt_pkg::eff_cfg_t  cfg,
	mnt_entry_if.sink          entries,
	output mnt_pkg::q_item_t   push_item,
	output logic               push_valid,
	input  logic               push_ready
);
	import mnt_pkg::*;

	logic [MAX_DIMS-1:0][BIN_W-1:0] digits_q;
	logic [MAX_DIMS-1:0][BIN_W-1:0] digits_next;
	logic                           carry;
	logic                           accept;

	// Each entry is tagged with the digit of the kept dimension.
	assign push_item.value = entries.entry_value;
	assign push_item.bin   = digits_q[cfg.keep];
	assign push_item.last  = entries.last_entry;
	assign push_valid      = entries.valid;
	assign entries.ready   = push_ready;
	assign accept          = entries.valid && push_ready;

	// Mixed-radix increment, innermost dimension first; a digit at or past its
	// cardinality wraps and carries outward.
	always_comb begin
		digits_next = digits_q;
		carry       = 1'b1;
		for (int i = MAX_DIMS - 1; i >= 0; i--) begin
			if ((i < int'(cfg.dims)) && carry) begin
				if (({1'b0, digits_q[i]} + CARD_W'(1)) >= cfg.card[i]) begin
					digits_next[i] = '0;
				end else begin
					digits_next[i] = digits_q[i] + BIN_W'(1);
					carry          = 1'b0;
				end
			end
		end
	end

	// The coordinate restarts at the origin after the last entry of a table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digits_q <= '0;
		end else if (accept) begin
			if (entries.last_entry) begin
				digits_q <= '0;
			end else begin
				digits_q <= digits_next;
			end
		end
	end

endmodule

// ----- hdl/mnt_queue.sv -----
module mnt_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  mnt_pkg::q_item_t  push_item,
	input  logic              push_valid,
	output logic              push_ready,
	output mnt_pkg::q_item_t  pop_item,
	output logic              pop_valid,
	input  logic              pop_ready
);
	import mnt_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	q_item_t          mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Storage of queued items.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers wrap around the depth; the count tells full from empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ----- hdl/mnt_back.sv -----
module mnt_back (
	input  logic              clk,
	input  logic              arst_n,
	input  mnt_pkg::eff_cfg_t cfg,
	input  mnt_pkg::q_item_t  pop_item,
	input  logic              pop_valid,
	output logic              pop_ready,
	mnt_result_if.source      results
);
	import mnt_pkg::*;

	localparam int STEP_W = $clog2(VALUE_BITS);

	back_state_t             state_q;
	back_state_t             state_next;

	logic [ACC_W-1:0]        bins_q [MAX_CARD];
	logic [MAX_CARD-1:0]     bin_vld_q;
	logic [ACC_W-1:0]        total_q;
	logic [BIN_W-1:0]        k_q;
	logic [ACC_W-1:0]        rem_q;
	logic [VALUE_BITS-1:0]   quot_q;
	logic                    zero_q;
	logic [STEP_W-1:0]       step_q;

	logic                    out_valid_q;
	logic [VALUE_BITS-1:0]   out_value_q;
	logic [BIN_W-1:0]        out_bin_q;
	logic                    out_last_q;
	logic                    out_zero_q;

	logic [BIN_W-1:0]        rd_addr;
	logic [ACC_W-1:0]        rd_data;
	logic [CARD_W-1:0]       bin_cnt;
	logic                    k_last;
	logic                    acc_en;
	logic                    load_out;
	logic                    run_done;
	logic                    total_zero;
	logic                    saturate;
	logic [ACC_W:0]          rem_dbl;
	logic                    rem_ge;
	logic [ACC_W:0]          rem_sub;

	// One read port on the bins: the accumulating entry's bin, or the bin being
	// normalized. A bin not touched since the last clear reads as zero.
	assign rd_addr = (state_q == BK_ACC) ? pop_item.bin : k_q;
	assign rd_data = bin_vld_q[rd_addr] ? bins_q[rd_addr] : '0;

	assign bin_cnt    = cfg.card[cfg.keep];
	assign k_last     = (({1'b0, k_q} + CARD_W'(1)) == bin_cnt);
	assign total_zero = (total_q == '0);
	assign saturate   = (rd_data >= total_q);

	// Restoring division step: the remainder stays below the total.
	assign rem_dbl = {rem_q, 1'b0};
	assign rem_ge  = (rem_dbl >= {1'b0, total_q});
	assign rem_sub = rem_dbl - {1'b0, total_q};

	// Handshake and enables derived from the state.
	always_comb begin
		pop_ready = (state_q == BK_ACC);
		acc_en    = (state_q == BK_ACC) && pop_valid;
		load_out  = (state_q == BK_EMIT) && (!out_valid_q || results.ready);
		run_done  = load_out && k_last;
	end

	// Next state.
	always_comb begin
		state_next = state_q;
		case (state_q)
			BK_ACC: begin
				if (acc_en && pop_item.last) begin
					state_next = BK_LOAD;
				end
			end
			BK_LOAD: begin
				if (total_zero || saturate) begin
					state_next = BK_EMIT;
				end else begin
					state_next = BK_DIV;
				end
			end
			BK_DIV: begin
				if (step_q == STEP_W'(VALUE_BITS - 1)) begin
					state_next = BK_EMIT;
				end
			end
			BK_EMIT: begin
				if (load_out) begin
					state_next = k_last ? BK_ACC : BK_LOAD;
				end
			end
			default: begin
				state_next = BK_ACC;
			end
		endcase
	end

	// Bin storage; valid bits handle the clear at reset and after each run.
	always_ff @(posedge clk) begin
		if (acc_en) begin
			bins_q[pop_item.bin] <= sat_add(rd_data, ACC_W'(pop_item.value));
		end
	end

	// Control state, total and bin counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_ACC;
			bin_vld_q <= '0;
			total_q   <= '0;
			k_q       <= '0;
		end else begin
			state_q <= state_next;
			if (acc_en) begin
				bin_vld_q[pop_item.bin] <= 1'b1;
				total_q                 <= sat_add(total_q, ACC_W'(pop_item.value));
			end else if (run_done) begin
				bin_vld_q <= '0;
				total_q   <= '0;
			end
			if (load_out) begin
				k_q <= k_last ? '0 : k_q + BIN_W'(1);
			end
		end
	end

	// Divider datapath: load a bin, then one quotient bit per cycle.
	always_ff @(posedge clk) begin
		if (state_q == BK_LOAD) begin
			rem_q  <= rd_data;
			zero_q <= total_zero;
			step_q <= '0;
			quot_q <= (!total_zero && saturate) ? {VALUE_BITS{1'b1}} : '0;
		end else if (state_q == BK_DIV) begin
			rem_q  <= rem_ge ? rem_sub[ACC_W-1:0] : rem_dbl[ACC_W-1:0];
			quot_q <= {quot_q[VALUE_BITS-2:0], rem_ge};
			step_q <= step_q + STEP_W'(1);
		end
	end

	// Output register: holds a finished result until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_value_q <= quot_q;
			out_bin_q   <= k_q;
			out_last_q  <= k_last;
			out_zero_q  <= zero_q;
		end
	end

	assign results.valid          = out_valid_q;
	assign results.marginal_value = out_value_q;
	assign results.bin_index      = out_bin_q;
	assign results.last_result    = out_last_q;
	assign results.zero_total     = out_zero_q;

endmodule

// ----- hdl/marginalize_normalize_table_unit.sv -----
// Entries pass through a 4-deep queue and are taken one per cycle while it has room.
// After the last entry each bin of the kept dimension is loaded, then emitted when the
// total is zero or the bin saturates, else run through 16 divider steps and emitted,
// all on one shared restoring divider. Entries of the next table queue meanwhile.
// Reset sets the registers to one dimension of one value, keeping dimension 0, and
// empties the bins at once through per-bin valid bits; no clearing pass is needed.
module marginalize_normalize_table_unit (
	input  logic          clk,
	input  logic          arst_n,
	mnt_cfg_if.sink       cfg,
	mnt_entry_if.sink     entries,
	mnt_result_if.source  results
);
	import mnt_pkg::*;

	logic [DIMS_W-1:0]               dims_q;
	logic [MAX_DIMS-1:0][CARD_W-1:0] card_q;
	logic [KEEP_W-1:0]               keep_q;
	eff_cfg_t                        eff_cfg;
	logic [DIMS_W-1:0]               dims_eff;

	q_item_t                         push_item;
	logic                            push_valid;
	logic                            push_ready;
	q_item_t                         pop_item;
	logic                            pop_valid;
	logic                            pop_ready;

	// Register writes; indexes past the list are ignored.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= DIMS_W'(1);
			card_q <= {MAX_DIMS{CARD_W'(1)}};
			keep_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_DIMS:  dims_q    <= cfg.data[DIMS_W-1:0];
				REG_CARD0: card_q[0] <= cfg.data[CARD_W-1:0];
				REG_CARD1: card_q[1] <= cfg.data[CARD_W-1:0];
				REG_CARD2: card_q[2] <= cfg.data[CARD_W-1:0];
				REG_CARD3: card_q[3] <= cfg.data[CARD_W-1:0];
				REG_KEEP:  keep_q    <= cfg.data[KEEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Clamp the registers into their legal ranges.
	always_comb begin
		dims_eff = dims_q;
		if (dims_q == '0) begin
			dims_eff = DIMS_W'(1);
		end else if (dims_q > DIMS_W'(MAX_DIMS)) begin
			dims_eff = DIMS_W'(MAX_DIMS);
		end
		eff_cfg.dims = dims_eff;
		for (int i = 0; i < MAX_DIMS; i++) begin
			eff_cfg.card[i] = clamp_card(card_q[i]);
		end
		if (DIMS_W'(keep_q) > (dims_eff - DIMS_W'(1))) begin
			eff_cfg.keep = KEEP_W'(dims_eff - DIMS_W'(1));
		end else begin
			eff_cfg.keep = keep_q;
		end
	end

	mnt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (eff_cfg),
		.entries    (entries),
		.push_item  (push_item),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	mnt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_item  (push_item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_item   (pop_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	mnt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (eff_cfg),
		.pop_item  (pop_item),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.results   (results)
	);

endmodule

// ----- hdl/mnt_checker.sv -----
module mnt_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           res_valid,
	input logic                           res_ready,
	input logic [mnt_pkg::VALUE_BITS-1:0] res_value,
	input logic [mnt_pkg::BIN_W-1:0]      res_bin,
	input logic                           res_last,
	input logic                           res_zero
);
	import mnt_pkg::*;

	// A stalled result keeps its contents.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_value) && $stable(res_bin)
			&& $stable(res_last) && $stable(res_zero))
		else $error("result changed while stalled");

	// A zero total always reports a zero value.
	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_zero |-> res_value == '0)
		else $error("zero total with nonzero value");

	// A bin that is not the final one cannot be the highest bin.
	a_not_last_bin: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_last |-> res_bin != BIN_W'(MAX_CARD - 1))
		else $error("highest bin not marked final");

	// Bins of one run come in ascending order and share the zero flag.
	a_bin_order: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !res_last ##1 res_valid |->
			res_bin == $past(res_bin) + BIN_W'(1) && res_zero == $past(res_zero))
		else $error("bin sequence broken within a run");

endmodule

bind marginalize_normalize_table_unit mnt_checker u_mnt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (results.valid),
	.res_ready (results.ready),
	.res_value (results.marginal_value),
	.res_bin   (results.bin_index),
	.res_last  (results.last_result),
	.res_zero  (results.zero_total)
);
